### rtl/lifo_stack_with_search_assert.svh
// Assertion macros shared by the stack RTL.
`ifndef LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_ASSERT_SVH

// Checks that a condition implies another condition in the same cycle.
`define LSTK_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Stack check failed in the same cycle.");

// Checks that a condition implies another condition in the next cycle.
`define LSTK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Stack check failed one cycle later.");

`endif

### rtl/lstk_pkg.sv
// Package with the request and status codes and the word types of the stack.
package lstk_pkg;

  localparam int WORD_W = 32;

  typedef logic [2:0]               req_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam req_t REQ_PUSH  = 3'd0;
  localparam req_t REQ_POP   = 3'd1;
  localparam req_t REQ_TOP   = 3'd2;
  localparam req_t REQ_FIND  = 3'd3;
  localparam req_t REQ_CPUSH = 3'd4;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_REFUSED = 2'd3;

endpackage

### rtl/lstk_mem.sv
// Entry memory of the stack: one write port and one registered read port.
module lstk_mem import lstk_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  word_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output word_t         rd_data
);

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/lifo_stack_with_search.sv
// Push, pop, and any request on an empty stack return their result in the cycle after
// acceptance; read top and conditional push first read the top entry in S_RDTOP, and a
// search over N stored entries reads them in S_SRCH, one memory read per entry.
// busy is high while a read top, conditional push or search is in progress; the next
// request can be accepted at the edge that takes the result, and results cannot stall.
// Reset clears the fill count and the control state; entries are not cleared.
module lifo_stack_with_search import lstk_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  req_t    in_req_type,
  input  word_t   in_operand,
  output logic    out_valid,
  output word_t   out_top_word,
  output logic    out_found,
  output logic    out_now_empty,
  output status_t out_status
);

  `include "lifo_stack_with_search_assert.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDTOP = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  req_t          req_r, req_nxt;
  word_t         opnd_r, opnd_nxt;

  logic          ov_r, ov_nxt;
  word_t         otw_r, otw_nxt;
  logic          of_r, of_nxt;
  logic          oe_r, oe_nxt;
  status_t       ost_r, ost_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;
  logic [AW-1:0] rd_addr;
  word_t         rd_data;

  logic [CW-1:0] count_m1;
  logic          is_empty;
  logic          is_full;

  assign count_m1 = count_r - CW'(1);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(STACK_DEPTH));

  lstk_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    req_nxt   = req_r;
    opnd_nxt  = opnd_r;
    ov_nxt    = 1'b0;
    otw_nxt   = '0;
    of_nxt    = 1'b0;
    ost_nxt   = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = count_r[AW-1:0];
    wr_data   = opnd_r;
    rd_addr   = count_m1[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_req_type;
          opnd_nxt = in_operand;
          wr_data  = in_operand;
          case (in_req_type)
            REQ_PUSH: begin
              ov_nxt = 1'b1;
              if (is_full) begin
                ost_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_POP: begin
              ov_nxt = 1'b1;
              if (is_empty) begin
                ost_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_m1;
              end
            end
            REQ_TOP: begin
              if (is_empty) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RDTOP;
              end
            end
            REQ_FIND: begin
              if (is_empty) begin
                ov_nxt = 1'b1;
              end else begin
                rd_addr   = '0;
                idx_nxt   = CW'(1);
                state_nxt = S_SRCH;
              end
            end
            REQ_CPUSH: begin
              if (is_empty) begin
                ov_nxt    = 1'b1;
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                state_nxt = S_RDTOP;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RDTOP: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (req_r == REQ_TOP) begin
          otw_nxt = rd_data;
        end else if (!(opnd_r < rd_data)) begin
          ost_nxt = ST_REFUSED;
        end else if (is_full) begin
          ost_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      S_SRCH: begin
        if (rd_data == opnd_r) begin
          ov_nxt    = 1'b1;
          of_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (idx_r == count_r) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_addr = idx_r[AW-1:0];
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    oe_nxt = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    req_r  <= req_nxt;
    opnd_r <= opnd_nxt;
    otw_r  <= otw_nxt;
    of_r   <= of_nxt;
    oe_r   <= oe_nxt;
    ost_r  <= ost_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_top_word  = otw_r;
  assign out_found     = of_r;
  assign out_now_empty = oe_r;
  assign out_status    = ost_r;

  `LSTK_ASSERT_SAME(a_count_range, 1'b1, count_r <= CW'(STACK_DEPTH))
  `LSTK_ASSERT_SAME(a_result_idle, out_valid, !busy)
  `LSTK_ASSERT_SAME(a_empty_flag, out_valid, out_now_empty == (count_r == '0))
  `LSTK_ASSERT_SAME(a_full_drop, out_valid && out_status == ST_FULL,
                    count_r == CW'(STACK_DEPTH))
  `LSTK_ASSERT_NEXT(a_pop_dec, start && !busy && in_req_type == REQ_POP && count_r != '0,
                    count_r == $past(count_r) - CW'(1))

endmodule
